// ===== hdl/dcm_pkg.sv =====
`timescale 1ns / 1ps
package dcm_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int COLOUR_W        = 24;
    localparam int DISP_W          = 16;
    localparam int BF_W            = 28;
    localparam int DIST_W          = 20;
    localparam int ENTRIES_W       = 13;
    localparam int EIDX_W          = 12;
    localparam int DIV_N_W         = 36;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 28;
    localparam int IN_DATA_W       = 56;
    localparam int OUT_DATA_W      = 32;
    localparam int DIV_STAGES      = 20;

    localparam logic [DIST_W-1:0]     DIST_SAT  = '1;
    localparam logic [COLOUR_W-1:0]   BLUE_RGB  = 24'h0000ff;
    localparam logic [COLOUR_W-1:0]   BLACK_RGB = 24'h000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DISP_MODE   = 3'd0,
        REG_DRAW_OUT    = 3'd1,
        REG_INF_OFFSET  = 3'd2,
        REG_BF_SCALED   = 3'd3,
        REG_MIN_DIST    = 3'd4,
        REG_MAX_DIST    = 3'd5,
        REG_MAX_DISP    = 3'd6,
        REG_TABLE_ENTRY = 3'd7
    } cfg_reg_t;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_PIXEL = 1'b1
    } op_t;

    typedef struct packed {
        logic                  disparity_mode;
        logic                  draw_outside;
        logic [DISP_W-1:0]     infinity_offset;
        logic [BF_W-1:0]       bf_scaled;
        logic [DIST_W-1:0]     near_limit;
        logic [DIST_W-1:0]     far_limit;
        logic [DISP_W-1:0]     disp_ceiling;
        logic [ENTRIES_W-1:0]  table_entries;
    } cfg_t;

    // per-pixel control that rides alongside the pipeline
    typedef struct packed {
        logic pixel;
        logic last;
        logic black;
        logic dist_mode;
        logic lookup;
    } pix_ctl_t;

endpackage

// ===== hdl/dcm_divider.sv =====
`timescale 1ns / 1ps
module dcm_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  dcm_pkg::pix_ctl_t            in_ctl,
    input  logic [dcm_pkg::BF_W-1:0]     in_num,
    input  logic [dcm_pkg::DISP_W-1:0]   in_den,
    input  logic [dcm_pkg::DISP_W-1:0]   in_alt,
    output logic                         out_valid,
    output dcm_pkg::pix_ctl_t            out_ctl,
    output logic [dcm_pkg::DIST_W-1:0]   out_quo,
    output logic [dcm_pkg::DISP_W-1:0]   out_alt
);
    import dcm_pkg::*;

    // restoring division, two quotient bits per stage; quotient saturates at 20 bits
    localparam int NS  = DIV_STAGES / 2;
    localparam int RW  = DISP_W + 1;

    logic              v_reg   [NS+1];
    pix_ctl_t          c_reg   [NS+1];
    logic [BF_W+7:0]   n_reg   [NS+1];
    logic [DISP_W-1:0] d_reg   [NS+1];
    logic [RW-1:0]     r_reg   [NS+1];
    logic [DIST_W-1:0] q_reg   [NS+1];
    logic              ovf_reg [NS+1];
    logic [DISP_W-1:0] a_reg   [NS+1];

    logic [RW-1:0]     r_next   [NS];
    logic [DIST_W-1:0] q_next   [NS];
    logic              ovf_next [NS];

    always_comb
    begin
        v_reg[0]   = in_valid;
        c_reg[0]   = in_ctl;
        n_reg[0]   = {in_num, 8'd0};
        d_reg[0]   = in_den;
        a_reg[0]   = in_alt;
        q_reg[0]   = '0;
        // high part of numerator beyond 20 quotient bits
        r_reg[0]   = '0;
        ovf_reg[0] = ({in_num, 8'd0} >> DIST_W) >= {{(BF_W+8-DISP_W){1'b0}}, in_den};
    end

    // partial remainder must start from high bits; these fit in 16 bits because no overflow
    logic [DISP_W-1:0] hi0;
    assign hi0 = DISP_W'({in_num, 8'd0} >> DIST_W);

    for (genvar s = 0; s < NS; s++) begin : g_st
        always_comb
        begin
            logic [RW-1:0]     r;
            logic [DIST_W-1:0] q;
            logic              bitv;
            r = (s == 0) ? {1'b0, hi0} : r_reg[s];
            q = q_reg[s];
            for (int k = 0; k < 2; k++) begin
                bitv = n_reg[s][DIST_W-1-2*s-k];
                r = {r[RW-2:0], bitv};
                q = {q[DIST_W-2:0], 1'b0};
                if (r >= {1'b0, d_reg[s]}) begin
                    r = r - {1'b0, d_reg[s]};
                    q[0] = 1'b1;
                end
            end
            r_next[s]   = r;
            q_next[s]   = q;
            ovf_next[s] = ovf_reg[s];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                v_reg[s+1] <= 1'b0;
            end else if (en) begin
                v_reg[s+1] <= v_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en) begin
                c_reg[s+1]   <= c_reg[s];
                n_reg[s+1]   <= n_reg[s];
                d_reg[s+1]   <= d_reg[s];
                a_reg[s+1]   <= a_reg[s];
                r_reg[s+1]   <= r_next[s];
                q_reg[s+1]   <= q_next[s];
                ovf_reg[s+1] <= ovf_next[s];
            end
        end
    end

    assign out_valid = v_reg[NS];
    assign out_ctl   = c_reg[NS];
    assign out_quo   = ovf_reg[NS] ? DIST_SAT : q_reg[NS];
    assign out_alt   = a_reg[NS];
endmodule

// ===== hdl/dcm_table.sv =====
`timescale 1ns / 1ps
module dcm_table #(
    parameter int TABLE_DEPTH = dcm_pkg::TABLE_DEPTH_DEF,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  logic                           clk,
    input  logic                           en,
    input  logic                           wr_en,
    input  logic [AW-1:0]                  wr_addr,
    input  logic [dcm_pkg::COLOUR_W-1:0]   wr_data,
    input  logic [AW-1:0]                  rd_addr,
    output logic [dcm_pkg::COLOUR_W-1:0]   rd_data
);
    import dcm_pkg::*;

    logic [COLOUR_W-1:0] mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ===== hdl/depth_colour_mapper.sv =====
`timescale 1ns / 1ps
// pipeline: 10 divider stages, index, table read, output
// throughput: one request per cycle unless the output stalls; table writes and pixels share the input stream
// table writes travel down a delay line and land at the lookup stage, in request order
// reset clears control and configuration registers; table contents stay undefined
// the pipeline stalls as a whole when the output register is full and not taken
module depth_colour_mapper #(
    parameter int TABLE_DEPTH = dcm_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dcm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dcm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // entry_index, entry_colour, disparity, pad
    input  logic [dcm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // op
    input  logic                             s_axis_tuser,
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // blue, green, red, alpha
    output logic [dcm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                             m_axis_tlast
);
    import dcm_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int VW = $clog2(TABLE_DEPTH + 1);
    localparam int WD = DIV_STAGES / 2 + 1;

    cfg_t cfg_reg;
    logic en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= '{disparity_mode: 1'b0, draw_outside: 1'b0, infinity_offset: '0,
                         bf_scaled: '0, near_limit: '0, far_limit: DIST_SAT,
                         disp_ceiling: 16'hff00, table_entries: '0};
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_DISP_MODE:   cfg_reg.disparity_mode  <= cfg_data[0];
                REG_DRAW_OUT:    cfg_reg.draw_outside    <= cfg_data[0];
                REG_INF_OFFSET:  cfg_reg.infinity_offset <= cfg_data[DISP_W-1:0];
                REG_BF_SCALED:   cfg_reg.bf_scaled       <= cfg_data[BF_W-1:0];
                REG_MIN_DIST:    cfg_reg.near_limit      <= cfg_data[DIST_W-1:0];
                REG_MAX_DIST:    cfg_reg.far_limit       <= cfg_data[DIST_W-1:0];
                REG_MAX_DISP:    cfg_reg.disp_ceiling    <= cfg_data[DISP_W-1:0];
                REG_TABLE_ENTRY: cfg_reg.table_entries   <= cfg_data[ENTRIES_W-1:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end
    assign cfg_ready = 1'b1;

    logic [EIDX_W-1:0]   in_eidx;
    logic [COLOUR_W-1:0] in_col;
    logic [DISP_W-1:0]   in_disp;
    assign in_eidx = s_axis_tdata[EIDX_W-1:0];
    assign in_col  = s_axis_tdata[EIDX_W+COLOUR_W-1:EIDX_W];
    assign in_disp = s_axis_tdata[EIDX_W+COLOUR_W+DISP_W-1:EIDX_W+COLOUR_W];

    logic in_acc;
    assign s_axis_tready = en;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // table write, delayed to the lookup stage
    logic                wd_v_reg    [WD];
    logic [AW-1:0]       wd_addr_reg [WD];
    logic [COLOUR_W-1:0] wd_data_reg [WD];
    logic                wr_ok;
    logic                tab_wr_en;
    assign wr_ok = (32'(in_eidx) < 32'(TABLE_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < WD; i++) begin
                wd_v_reg[i] <= 1'b0;
            end
        end else if (en) begin
            wd_v_reg[0] <= in_acc && (op_t'(s_axis_tuser) == OP_WRITE) && wr_ok;
            for (int i = 1; i < WD; i++) begin
                wd_v_reg[i] <= wd_v_reg[i-1];
            end
        end
    end
    always_ff @(posedge clk)
    begin
        if (en) begin
            wd_addr_reg[0] <= AW'(in_eidx);
            wd_data_reg[0] <= in_col;
            for (int i = 1; i < WD; i++) begin
                wd_addr_reg[i] <= wd_addr_reg[i-1];
                wd_data_reg[i] <= wd_data_reg[i-1];
            end
        end
    end
    assign tab_wr_en = wd_v_reg[WD-1] && en;

    // front stage: black test, disparity-mode value
    pix_ctl_t            f_ctl;
    logic [DISP_W-1:0]   f_den;
    logic [DISP_W-1:0]   f_alt;
    logic [DISP_W+1:0]   f_dm;
    always_comb
    begin
        f_ctl.pixel     = in_acc && (op_t'(s_axis_tuser) == OP_PIXEL);
        f_ctl.last      = s_axis_tlast;
        f_ctl.black     = in_disp <= cfg_reg.infinity_offset;
        f_ctl.dist_mode = !cfg_reg.disparity_mode;
        f_ctl.lookup    = 1'b0;
        f_den = f_ctl.black ? 16'd1 : (in_disp - cfg_reg.infinity_offset);
        f_dm  = {2'b0, cfg_reg.disp_ceiling} - {2'b0, in_disp}
              - {2'b0, cfg_reg.infinity_offset};
        f_alt = f_dm[DISP_W+1] ? '0 : f_dm[DISP_W-1:0];
    end

    logic              dv;
    pix_ctl_t          dctl;
    logic [DIST_W-1:0] dquo;
    logic [DISP_W-1:0] dalt;

    dcm_divider u_div (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(f_ctl.pixel), .in_ctl(f_ctl),
        .in_num(cfg_reg.bf_scaled), .in_den(f_den), .in_alt(f_alt),
        .out_valid(dv), .out_ctl(dctl), .out_quo(dquo), .out_alt(dalt)
    );

    // index stage
    logic [VW-1:0] valid_n;
    assign valid_n = (32'(cfg_reg.table_entries) > 32'(TABLE_DEPTH))
                   ? VW'(TABLE_DEPTH) : VW'(cfg_reg.table_entries);

    logic [11:0]   idx_raw;
    logic          idx_in;
    logic          in_rng;
    pix_ctl_t      lk_ctl_next;
    logic          lk_v_reg;
    pix_ctl_t      lk_ctl_reg;
    logic [AW-1:0] lk_addr_reg;
    logic          lk_blue_reg;
    always_comb
    begin
        idx_raw = dctl.dist_mode ? dquo[DIST_W-1:8] : {2'b0, dalt[DISP_W-1:6]};
        idx_in  = 32'(idx_raw) < 32'(valid_n);
        in_rng  = (dquo <= cfg_reg.far_limit) && (dquo >= cfg_reg.near_limit);
        lk_ctl_next        = dctl;
        lk_ctl_next.lookup = !dctl.black && idx_in
                           && (!dctl.dist_mode || cfg_reg.draw_outside || in_rng);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            lk_v_reg <= 1'b0;
        end else if (en) begin
            lk_v_reg <= dv;
        end
    end
    always_ff @(posedge clk)
    begin
        if (en) begin
            lk_ctl_reg        <= lk_ctl_next;
            lk_blue_reg       <= !dctl.black && dctl.dist_mode && cfg_reg.draw_outside
                               && !idx_in;
            lk_addr_reg       <= AW'(idx_raw);
        end
    end

    logic [COLOUR_W-1:0] rd_data;
    dcm_table #(.TABLE_DEPTH(TABLE_DEPTH), .AW(AW)) u_tab (
        .clk(clk), .en(en),
        .wr_en(tab_wr_en), .wr_addr(wd_addr_reg[WD-1]), .wr_data(wd_data_reg[WD-1]),
        .rd_addr(lk_addr_reg), .rd_data(rd_data)
    );

    logic     rd_v_reg;
    pix_ctl_t rd_ctl_reg;
    logic     rd_blue_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rd_v_reg <= 1'b0;
        end else if (en) begin
            rd_v_reg <= lk_v_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (en) begin
            rd_ctl_reg  <= lk_ctl_reg;
            rd_blue_reg <= lk_blue_reg;
        end
    end

    // output register
    logic                out_v_reg;
    logic [COLOUR_W-1:0] out_rgb_reg;
    logic                out_last_reg;
    assign en = !out_v_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_v_reg <= 1'b0;
        end else if (en) begin
            out_v_reg <= rd_v_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (en) begin
            out_rgb_reg  <= rd_ctl_reg.lookup ? rd_data
                          : (rd_blue_reg ? BLUE_RGB : BLACK_RGB);
            out_last_reg <= rd_ctl_reg.last;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {8'hff, out_rgb_reg[23:16], out_rgb_reg[15:8], out_rgb_reg[7:0]};
    assign m_axis_tlast  = out_last_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |-> !s_axis_tready)
        else $error("input taken during stall");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rd_ctl_reg.lookup && rd_v_reg |-> !rd_blue_reg)
        else $error("lookup and blue both set");
endmodule

// ===== dv/depth_colour_mapper_test.sv =====
`timescale 1ns / 1ps
module depth_colour_mapper_test;
    import dcm_pkg::*;

    localparam int DEPTH       = TABLE_DEPTH_DEF;
    localparam int FILL        = 512;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 30;

    typedef struct {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
        logic       last;
    } bgra_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata;
    logic                    s_axis_tuser;
    logic                    s_axis_tlast;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    m_axis_tlast;

    // shadow of the block's configuration and colour table
    logic                    sh_disp_mode;
    logic                    sh_draw_out;
    logic [DISP_W-1:0]       sh_inf_offset;
    logic [BF_W-1:0]         sh_bf;
    logic [DIST_W-1:0]       sh_min_dist;
    logic [DIST_W-1:0]       sh_max_dist;
    logic [DISP_W-1:0]       sh_max_disp;
    logic [ENTRIES_W-1:0]    sh_entries;
    logic [COLOUR_W-1:0]     colour_shadow [DEPTH];

    bgra_t                   pending_pixels [$];
    int                      errors;
    int                      mismatches;
    int                      pixels_checked;
    int                      writes_sent;
    int                      cycles;
    int                      hold_cycles;
    bit                      no_idle;

    depth_colour_mapper i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_pixels.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: random stalls, a no-stall stretch, and a long hold-off
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_axis_tready = 1'b0;
            hold_cycles--;
        end
        else if (no_idle)
            m_axis_tready = 1'b1;
        else
            m_axis_tready = ($urandom_range(99) >= 34);
    end

    function automatic logic [COLOUR_W-1:0] colour_at(input logic [31:0] idx, input bit outside,
                                                      output bit hit);
        int valid;
        valid = (sh_entries > DEPTH) ? DEPTH : sh_entries;
        hit = (idx < valid);
        colour_at = hit ? colour_shadow[idx] : (outside ? BLUE_RGB : BLACK_RGB);
    endfunction

    function automatic logic [COLOUR_W-1:0] pixel_colour(input logic [DISP_W-1:0] disp);
        logic [63:0] zdist;
        logic [63:0] delta;
        int          sdelta;
        bit          hit;
        pixel_colour = BLACK_RGB;
        if (disp > sh_inf_offset)
        begin
            if (!sh_disp_mode)
            begin
                delta = disp - sh_inf_offset;
                zdist = ({36'd0, sh_bf} << 8) / delta;
                if (zdist > 64'(DIST_SAT))
                    zdist = 64'(DIST_SAT);
                if (sh_draw_out)
                    pixel_colour = colour_at(32'(zdist >> 8), 1'b1, hit);
                else if (zdist <= sh_max_dist && zdist >= sh_min_dist)
                    pixel_colour = colour_at(32'(zdist >> 8), 1'b0, hit);
            end
            else
            begin
                sdelta = int'(sh_max_disp) - int'(disp) - int'(sh_inf_offset);
                if (sdelta < 0)
                    sdelta = 0;
                pixel_colour = colour_at(32'(sdelta >> 6), 1'b0, hit);
            end
        end
    endfunction

    always @(posedge clk)
    begin
        bgra_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_pixels.size() == 0)
            begin
                errors++;
                $display("unexpected result %h", m_axis_tdata);
            end
            else
            begin
                want = pending_pixels.pop_front();
                pixels_checked++;
                if (m_axis_tdata[7:0] !== want.blue || m_axis_tdata[15:8] !== want.green ||
                    m_axis_tdata[23:16] !== want.red || m_axis_tdata[31:24] !== want.alpha ||
                    m_axis_tlast !== want.last)
                begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected b%h g%h r%h a%h l%b, got b%h g%h r%h a%h l%b",
                                 want.blue, want.green, want.red, want.alpha, want.last,
                                 m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                                 m_axis_tdata[31:24], m_axis_tlast);
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_DISP_MODE:   sh_disp_mode  = value[0];
            REG_DRAW_OUT:    sh_draw_out   = value[0];
            REG_INF_OFFSET:  sh_inf_offset = value[DISP_W-1:0];
            REG_BF_SCALED:   sh_bf         = value[BF_W-1:0];
            REG_MIN_DIST:    sh_min_dist   = value[DIST_W-1:0];
            REG_MAX_DIST:    sh_max_dist   = value[DIST_W-1:0];
            REG_MAX_DISP:    sh_max_disp   = value[DISP_W-1:0];
            REG_TABLE_ENTRY: sh_entries    = value[ENTRIES_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_item(input op_t op, input logic [EIDX_W-1:0] eidx,
                             input logic [COLOUR_W-1:0] colour, input logic [DISP_W-1:0] disp,
                             input logic last);
        bgra_t want;
        logic [COLOUR_W-1:0] rgb;
        while (!no_idle && $urandom_range(99) < 34)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tlast  = last;
        s_axis_tdata  = {4'd0, disp, colour, eidx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (op == OP_WRITE)
        begin
            colour_shadow[eidx] = colour;
            writes_sent++;
        end
        else
        begin
            rgb        = pixel_colour(disp);
            want.blue  = rgb[7:0];
            want.green = rgb[15:8];
            want.red   = rgb[23:16];
            want.alpha = 8'hff;
            want.last  = last;
            pending_pixels.push_back(want);
        end
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic send_pixel(input logic [DISP_W-1:0] disp, input logic last);
        send_item(OP_PIXEL, EIDX_W'($urandom), COLOUR_W'($urandom), disp, last);
    endtask

    // the low entries plus the top entry are written; reads stay inside them
    task automatic test_table_fill();
        for (int i = 0; i < FILL; i++)
            send_item(OP_WRITE, EIDX_W'(i), (i == 0) ? 24'hffffff : COLOUR_W'($urandom),
                      DISP_W'($urandom), 1'($urandom));
        send_item(OP_WRITE, EIDX_W'(DEPTH - 1), COLOUR_W'($urandom), DISP_W'($urandom),
                  1'($urandom));
        write_reg(REG_TABLE_ENTRY, CFG_DATA_W'(DEPTH));
    endtask

    task automatic test_distance_directed();
        write_reg(REG_INF_OFFSET, 28'h100);
        write_reg(REG_BF_SCALED, 28'h1000);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'h0100, 1'b1);
        send_pixel(16'h0101, 1'b0);
        send_pixel(16'hffff, 1'b1);
        send_pixel(16'h0200, 1'b0);
        send_item(OP_WRITE, 12'hfff, 24'h000000, 16'h0, 1'b0);
        send_pixel(16'h0101, 1'b0);
        write_reg(REG_MIN_DIST, 28'h800);
        write_reg(REG_MAX_DIST, 28'h10000);
        send_pixel(16'h0101, 1'b0);
        send_pixel(16'h0180, 1'b0);
        send_pixel(16'hffff, 1'b0);
        write_reg(REG_TABLE_ENTRY, 28'd100);
        send_pixel(16'h0180, 1'b1);
        write_reg(REG_DRAW_OUT, 28'd1);
        send_pixel(16'h0101, 1'b0);
        send_pixel(16'hffff, 1'b0);
        send_pixel(16'h0100, 1'b1);
        write_reg(REG_BF_SCALED, 28'hfffffff);
        send_pixel(16'hffff, 1'b0);
        write_reg(REG_TABLE_ENTRY, 28'd0);
        send_pixel(16'hffff, 1'b1);
    endtask

    task automatic test_disparity_directed();
        write_reg(REG_DISP_MODE, 28'd1);
        write_reg(REG_TABLE_ENTRY, CFG_DATA_W'(FILL));
        write_reg(REG_INF_OFFSET, 28'd0);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'h0001, 1'b0);
        send_pixel(16'hff00, 1'b0);
        send_pixel(16'hffff, 1'b1);
        write_reg(REG_MAX_DISP, 28'hffff);
        send_pixel(16'h0001, 1'b0);
        write_reg(REG_TABLE_ENTRY, 28'd16);
        send_pixel(16'h0001, 1'b1);
        send_pixel(16'hfc00, 1'b0);
    endtask

    task automatic random_config();
        write_reg(REG_DISP_MODE, 28'($urandom_range(1)));
        write_reg(REG_DRAW_OUT, 28'($urandom_range(1)));
        case ($urandom_range(3))
            0: write_reg(REG_INF_OFFSET, 28'd0);
            1: write_reg(REG_INF_OFFSET, 28'hffff);
            default: write_reg(REG_INF_OFFSET, 28'($urandom_range(16'h3000)));
        endcase
        case ($urandom_range(3))
            0: write_reg(REG_BF_SCALED, 28'hfffffff);
            1: write_reg(REG_BF_SCALED, 28'($urandom));
            default: write_reg(REG_BF_SCALED, 28'($urandom_range(28'h200000)));
        endcase
        write_reg(REG_MIN_DIST, ($urandom_range(2) == 0) ? 28'd0 : 28'($urandom_range(20'h40000)));
        write_reg(REG_MAX_DIST, ($urandom_range(2) == 0) ? 28'hfffff : 28'($urandom));
        write_reg(REG_MAX_DISP, ($urandom_range(2) == 0) ? 28'hffff : 28'($urandom));
        write_reg(REG_TABLE_ENTRY, ($urandom_range(1) == 0) ? CFG_DATA_W'(FILL)
                                                            : 28'($urandom_range(FILL)));
    endtask

    task automatic random_traffic(input int count);
        logic [DISP_W-1:0] disp;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 15)
                send_item(OP_WRITE, EIDX_W'($urandom), COLOUR_W'($urandom),
                          DISP_W'($urandom), 1'($urandom));
            else
            begin
                disp = ($urandom_range(1) == 0) ? DISP_W'($urandom)
                                                : DISP_W'(sh_inf_offset + $urandom_range(2048));
                send_pixel(disp, 1'($urandom_range(9) == 0));
            end
        end
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < 6; p++)
        begin
            random_config();
            no_idle = (p == 2);
            random_traffic(120);
            no_idle = 1'b0;
        end
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_cycles = 400;
        random_traffic(150);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        hold_cycles   = 0;
        no_idle       = 1'b0;
        errors        = 0;
        mismatches    = 0;
        cycles        = 0;
        pixels_checked = 0;
        writes_sent   = 0;
        sh_disp_mode  = 1'b0;
        sh_draw_out   = 1'b0;
        sh_inf_offset = '0;
        sh_bf         = '0;
        sh_min_dist   = '0;
        sh_max_dist   = DIST_SAT;
        sh_max_disp   = 16'hff00;
        sh_entries    = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_table_fill();
        test_distance_directed();
        test_disparity_directed();
        test_random_phases();
        test_backpressure();

        wait_drained();
        repeat (SETTLE) @(negedge clk);
        $display("covered %0d table writes and %0d coloured pixels over distance and",
                 writes_sent, pixels_checked);
        $display("disparity modes, range limits, clipping and a long output stall");
        if (errors == 0 && pending_pixels.size() == 0)
            $display("[ OK ] regression clean");
        else
        begin
            $display("%0d errors, %0d mismatches, %0d results missing", errors, mismatches,
                     pending_pixels.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
